// File: sv/string_to_integer_parser_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef STRING_TO_INTEGER_PARSER_UNIT_MACROS_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, reset masked
`define SIP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked
`define SIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sip_pkg.sv
package sip_pkg;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int RADIX_W  = 6;
    localparam int VALUE_W  = 64;
    localparam int POS_W    = 16;
    localparam int DIGIT_W  = 7;

    // Saturation limit for byte counts
    localparam logic [POS_W-1:0] MAX_STRING_LEN = 16'hFFFF;

    // Radix after reset
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Radix codes with special handling
    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;

    // Digit value for bytes that are no digit at all
    localparam logic [DIGIT_W-1:0] NOT_DIGIT = 7'd99;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;

    // Parser phase
    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_START  = 3'd1,
        PH_ZERO   = 3'd2,
        PH_XPRE   = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // One input request: a byte of the string
    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              last_byte;
    } char_item_t;

    // One result request: the parsed string
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   consumed;
        logic               any_digits;
        logic               overflowed;
        logic               is_negative;
    } result_item_t;

    // Digit value of a byte: 0-9, letters 10-35, else NOT_DIGIT
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        begin
            diff = '0;
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                diff = c - CH_ZERO;
                digit_value = diff[DIGIT_W-1:0];
            end
            else if (c >= CH_LO_A && c <= CH_LO_Z)
            begin
                diff = c - CH_LO_A + 8'd10;
                digit_value = diff[DIGIT_W-1:0];
            end
            else if (c >= CH_UP_A && c <= CH_UP_Z)
            begin
                diff = c - CH_UP_A + 8'd10;
                digit_value = diff[DIGIT_W-1:0];
            end
            else
            begin
                digit_value = NOT_DIGIT;
            end
        end
    endfunction

endpackage

// File: sv/sip_stream_if.sv
// Valid/ready channel carrying one payload per request
interface sip_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/string_to_integer_parser_unit.sv
// strtol-style parser. Bytes of a string arrive on text, one per request, the
// final one marked by last_byte; one result follows each string on result.
// Leading whitespace is skipped, an optional sign taken, a 0x/0X prefix
// stripped for radix 0 or 16, and radix 0 picks octal after a leading zero,
// else decimal. Digits are gathered mod 2^64 while below the base; overflowed
// flags a wrap, consumed counts bytes through the last digit (saturating at
// MAX_STRING_LEN, 65535 by default). The block takes one byte per clock cycle
// while no stall holds it: every byte passes an input register and then one
// 64x6 multiply-add that updates the accumulator, which is the loop that sets
// the rate. A result is registered in an output register when its last byte
// leaves the input register, so bytes of the next string keep flowing while it
// waits; only a second last byte stalls behind an untaken result. radix is
// written through radix_wr_en/radix_wr_data and is latched per string at its
// first non-blank, non-sign byte. No clearing pass after reset.
module string_to_integer_parser_unit #(
    parameter logic [sip_pkg::POS_W-1:0] MAX_STRING_LEN = sip_pkg::MAX_STRING_LEN
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         radix_wr_en,
    input  logic [sip_pkg::RADIX_W-1:0]  radix_wr_data,
    sip_stream_if.sink                   text,
    sip_stream_if.source                 result
);

    localparam int VW = sip_pkg::VALUE_W;
    localparam int RW = sip_pkg::RADIX_W;
    localparam int PW = sip_pkg::POS_W;
    localparam int DW = sip_pkg::DIGIT_W;
    localparam int CW = sip_pkg::CHAR_W;

    // Configuration
    logic [RW-1:0] radix_reg;

    // Input stage
    logic          s1_valid_reg;
    logic [CW-1:0] s1_byte_reg;
    logic          s1_last_reg;

    // Parse state
    sip_pkg::phase_t phase_reg, phase_next;
    logic            neg_reg, neg_next;
    logic [VW-1:0]   acc_reg, acc_next;
    logic            seen_reg, seen_next;
    logic [RW-1:0]   base_reg, base_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [PW-1:0]   end_reg, end_next;
    logic            wrap_reg, wrap_next;

    // Result register
    logic            out_valid_reg;
    logic [VW-1:0]   res_mag_reg;
    logic [PW-1:0]   res_consumed_reg;
    logic            res_any_reg;
    logic            res_ovf_reg;
    logic            res_neg_reg;

    // Handshake
    logic out_free;
    logic s1_go;
    logic take_in;
    logic emit;

    // Datapath helpers
    logic [CW-1:0]   c;
    logic            is_blank;
    logic            is_sign;
    logic            is_x;
    logic            first_case;
    logic            zero_prefix;
    logic [RW-1:0]   base_first;
    logic [RW-1:0]   eff_base;
    logic [DW-1:0]   dval;
    logic            digit_ok;
    logic [VW+RW-1:0] mac;
    logic [PW-1:0]   pos_inc;

    // Flow control
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_go      = s1_valid_reg && (!s1_last_reg || out_free);
    assign text.ready = !s1_valid_reg || s1_go;
    assign take_in    = text.valid && text.ready;
    assign emit       = s1_go && s1_last_reg;

    // Byte classification
    assign c        = s1_byte_reg;
    assign is_blank = (c >= sip_pkg::CH_TAB && c <= sip_pkg::CH_CR) || c == sip_pkg::CH_SPACE;
    assign is_sign  = c == sip_pkg::CH_PLUS || c == sip_pkg::CH_MINUS;
    assign is_x     = c == sip_pkg::CH_LO_X || c == sip_pkg::CH_UP_X;
    assign dval     = sip_pkg::digit_value(c);

    // First byte after blanks and sign picks the base
    assign first_case  = (phase_reg == sip_pkg::PH_SPACE && !is_blank && !is_sign)
                         || phase_reg == sip_pkg::PH_START;
    assign zero_prefix = first_case && c == sip_pkg::CH_ZERO
                         && (radix_reg == sip_pkg::RADIX_AUTO || radix_reg == sip_pkg::RADIX_HEX);
    assign base_first  = (radix_reg == sip_pkg::RADIX_AUTO) ? sip_pkg::RADIX_DEC : radix_reg;
    assign eff_base    = first_case ? base_first : base_reg;
    assign digit_ok    = dval < {{(DW-RW){1'b0}}, eff_base};

    // Multiply-add; any bit from 64 up means the accumulator wrapped
    assign mac = {{RW{1'b0}}, acc_reg} * {{VW{1'b0}}, eff_base}
               + {{(VW+RW-DW){1'b0}}, dval};

    // Saturating byte index
    assign pos_inc = (pos_reg < MAX_STRING_LEN) ? pos_reg + 1'b1 : MAX_STRING_LEN;

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        base_next  = base_reg;
        end_next   = end_reg;
        wrap_next  = wrap_reg;
        pos_next   = pos_inc;

        case (phase_reg)
            sip_pkg::PH_SPACE,
            sip_pkg::PH_START,
            sip_pkg::PH_ZERO,
            sip_pkg::PH_XPRE,
            sip_pkg::PH_DIGITS:
            begin
                if (phase_reg == sip_pkg::PH_SPACE && is_blank)
                begin
                    phase_next = sip_pkg::PH_SPACE;
                end
                else if (phase_reg == sip_pkg::PH_SPACE && is_sign)
                begin
                    neg_next   = c == sip_pkg::CH_MINUS;
                    phase_next = sip_pkg::PH_START;
                end
                else if (zero_prefix)
                begin
                    // leading zero counts as a digit unless hex digits follow 0x
                    base_next  = (radix_reg == sip_pkg::RADIX_HEX) ? sip_pkg::RADIX_HEX
                                                                    : sip_pkg::RADIX_OCT;
                    acc_next   = '0;
                    seen_next  = 1'b1;
                    end_next   = pos_inc;
                    phase_next = sip_pkg::PH_ZERO;
                end
                else if (phase_reg == sip_pkg::PH_ZERO && is_x)
                begin
                    base_next  = sip_pkg::RADIX_HEX;
                    phase_next = sip_pkg::PH_XPRE;
                end
                else
                begin
                    if (first_case)
                    begin
                        base_next = base_first;
                    end
                    if (digit_ok)
                    begin
                        acc_next   = mac[VW-1:0];
                        wrap_next  = wrap_reg || (mac[VW+RW-1:VW] != '0);
                        seen_next  = 1'b1;
                        end_next   = pos_inc;
                        phase_next = sip_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = sip_pkg::PH_DONE;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= sip_pkg::RADIX_RESET;
        end
        else if (radix_wr_en)
        begin
            radix_reg <= radix_wr_data;
        end
    end

    // Control and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= sip_pkg::PH_SPACE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            seen_reg      <= 1'b0;
            base_reg      <= '0;
            pos_reg       <= '0;
            end_reg       <= '0;
            wrap_reg      <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // a finished string returns the parser to its reset state
            if (emit)
            begin
                phase_reg <= sip_pkg::PH_SPACE;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                seen_reg  <= 1'b0;
                base_reg  <= '0;
                pos_reg   <= '0;
                end_reg   <= '0;
                wrap_reg  <= 1'b0;
            end
            else if (s1_go)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                seen_reg  <= seen_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                end_reg   <= end_next;
                wrap_reg  <= wrap_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_byte_reg <= text.data.char_byte;
            s1_last_reg <= text.data.last_byte;
        end
        if (emit)
        begin
            res_mag_reg      <= acc_next;
            res_consumed_reg <= end_next;
            res_any_reg      <= seen_next;
            res_ovf_reg      <= wrap_next;
            res_neg_reg      <= neg_next;
        end
    end

    // Result; magnitude is zero when no digit was seen
    assign result.valid            = out_valid_reg;
    assign result.data.value       = res_neg_reg ? ('0 - res_mag_reg) : res_mag_reg;
    assign result.data.consumed    = res_consumed_reg;
    assign result.data.any_digits  = res_any_reg;
    assign result.data.overflowed  = res_ovf_reg;
    assign result.data.is_negative = res_neg_reg;

endmodule

// File: sv/sip_checker.sv
`include "string_to_integer_parser_unit_macros.svh"

// Port-level checks on the result channel
module sip_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sip_pkg::VALUE_W-1:0] out_value,
    input logic [sip_pkg::POS_W-1:0]   out_consumed,
    input logic                        out_any_digits,
    input logic                        out_overflowed
);

    // a stalled result stays offered
    `SIP_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // no digits means zero value and nothing consumed
    `SIP_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && !out_any_digits, out_value == '0 && out_consumed == '0, "empty parse gave nonzero fields")

    // a digit always consumes at least one byte
    `SIP_ASSERT_SAME(a_digit_count, clk, rst_n, out_valid && out_any_digits, out_consumed != '0, "digits with zero count")

    // wrap needs a digit
    `SIP_ASSERT_SAME(a_ovf_digits, clk, rst_n, out_valid && out_overflowed, out_any_digits, "overflow without digits")

endmodule

bind string_to_integer_parser_unit sip_checker u_sip_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_value      (result.data.value),
    .out_consumed   (result.data.consumed),
    .out_any_digits (result.data.any_digits),
    .out_overflowed (result.data.overflowed)
);
